// ----- rtl/core/psql_pkg.sv -----
// Shared constants, types and the command decode for the positional stack/queue list.
`timescale 1ns / 1ps
package psql_pkg;

    localparam int DEPTH         = 8;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int CMD_W    = 3;
    localparam int POS_W    = 4;
    localparam int FPAY_W   = 32;
    localparam int SEX_W    = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 4;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    localparam logic [SEX_W-1:0] SEX_A = 2'd1;
    localparam logic [SEX_W-1:0] SEX_B = 2'd2;

    typedef logic [AW-1:0]            t_addr;
    typedef logic [CW-1:0]            t_fill;
    typedef logic [XW-1:0]            t_wide;
    typedef logic [PAYLOAD_WIDTH-1:0] t_pay;
    typedef logic [FPAY_W-1:0]        t_fpay;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_DEQ   = 3'd2,
        CMD_SPUSH = 3'd3,
        CMD_SPOP  = 3'd4,
        CMD_SENQ  = 3'd5,
        CMD_SDEQ  = 3'd6,
        CMD_NOP   = 3'd7
    } t_cmd_code;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FULL   = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_BADPOS = 3'd3,
        ST_BADSEX = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_MV,
        S_PUT,
        S_TAKE,
        S_REM_MV,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [SEX_W-1:0] sex;
        t_pay             payload;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [POS_W-1:0] position;
        t_fpay            payload;
        logic [SEX_W-1:0] sex;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        t_fpay              payload;
        logic [SEX_W-1:0]   sex;
        logic [COUNT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic   wr_en;
        t_addr  wr_addr;
        t_entry wr_data;
        logic   rd_en;
        t_addr  rd_addr;
    } t_mem_req;

    typedef struct packed {
        t_status status;
        t_op     op;
        t_addr   at;
        t_addr   first;
        t_addr   last;
        logic    moves;
        t_fill   fill_next;
    } t_plan;

    function automatic t_pay fit_pay(input t_fpay x);
        logic [PAYLOAD_WIDTH+FPAY_W-1:0] w;
        w = {{PAYLOAD_WIDTH{1'b0}}, x};
        return w[PAYLOAD_WIDTH-1:0];
    endfunction

    function automatic t_fpay unfit_pay(input t_pay x);
        logic [PAYLOAD_WIDTH+FPAY_W-1:0] w;
        w = {{FPAY_W{1'b0}}, x};
        return w[FPAY_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] count_out(input t_fill fill);
        t_wide w;
        w = XW'(fill);
        return w[COUNT_W-1:0];
    endfunction

    // Checks one command against the current fill and works out the shift plan.
    function automatic t_plan plan_step(input logic [CMD_W-1:0] cmd,
                                        input logic [POS_W-1:0] pos,
                                        input logic [SEX_W-1:0] sex,
                                        input t_fill            fill);
        t_plan     pl;
        t_cmd_code code;
        t_wide     f;
        t_wide     p;
        t_wide     hi;
        t_wide     idx;
        t_wide     fm1;
        t_wide     ip1;
        t_wide     nxt;
        logic      full;
        logic      empty;
        logic      sex_ok;
        logic      do_ins;
        logic      do_rem;
        code   = t_cmd_code'(cmd);
        f      = XW'(fill);
        p      = XW'(pos);
        fm1    = f - XW'(1);
        full   = (f >= XW'(DEPTH));
        empty  = (f == '0);
        sex_ok = (sex == SEX_A) || (sex == SEX_B);
        do_ins = 1'b0;
        do_rem = 1'b0;
        idx    = '0;
        hi     = '0;
        pl     = '0;
        pl.status = ST_OK;
        unique case (code) inside
            CMD_PUSH: begin
                if (full) pl.status = ST_FULL;
                else begin
                    do_ins = 1'b1;
                    idx    = f;
                end
            end
            CMD_POP: begin
                if (empty) pl.status = ST_EMPTY;
                else begin
                    do_rem = 1'b1;
                    idx    = fm1;
                end
            end
            CMD_DEQ: begin
                if (empty) pl.status = ST_EMPTY;
                else do_rem = 1'b1;
            end
            CMD_SPUSH, CMD_SENQ: begin
                hi = f + ((code == CMD_SENQ) ? XW'(1) : XW'(0));
                if (empty) do_ins = 1'b1;
                else if (full) pl.status = ST_FULL;
                else if (p < XW'(2) || p > hi) pl.status = ST_BADPOS;
                else begin
                    do_ins = 1'b1;
                    idx    = p - XW'(1);
                end
            end
            CMD_SPOP, CMD_SDEQ: begin
                hi = f - ((code == CMD_SPOP) ? XW'(1) : XW'(0));
                if (empty) pl.status = ST_EMPTY;
                else if (f == XW'(1)) do_rem = 1'b1;
                else if (p < XW'(2) || p > hi) pl.status = ST_BADPOS;
                else begin
                    do_rem = 1'b1;
                    idx    = p - XW'(1);
                end
            end
            default: ;
        endcase
        if (do_ins && !sex_ok) begin
            pl.status = ST_BADSEX;
            do_ins    = 1'b0;
        end
        ip1 = idx + XW'(1);
        if (do_ins) begin
            pl.op    = OP_INSERT;
            pl.first = fm1[AW-1:0];
            pl.last  = idx[AW-1:0];
            pl.moves = (idx != f);
            nxt      = f + XW'(1);
        end else if (do_rem) begin
            pl.op    = OP_REMOVE;
            pl.first = ip1[AW-1:0];
            pl.last  = fm1[AW-1:0];
            pl.moves = (idx != fm1);
            nxt      = fm1;
        end else begin
            pl.op    = OP_NONE;
            pl.first = '0;
            pl.last  = '0;
            pl.moves = 1'b0;
            nxt      = f;
        end
        pl.at        = idx[AW-1:0];
        pl.fill_next = nxt[CW-1:0];
        return pl;
    endfunction

endpackage

// ----- rtl/core/psql_cmd_if.sv -----
// Command channel interface: valid/ready plus the command fields.
`timescale 1ns / 1ps
interface psql_cmd_if import psql_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [POS_W-1:0]    position;
    logic [FPAY_W-1:0]   entry_payload;
    logic [SEX_W-1:0]    entry_sex;

    modport source (output valid, command, position, entry_payload, entry_sex,
                    input ready);
    modport sink   (input valid, command, position, entry_payload, entry_sex,
                    output ready);
endinterface

// ----- rtl/core/psql_res_if.sv -----
// Result channel interface: valid/ready plus the result fields.
`timescale 1ns / 1ps
interface psql_res_if import psql_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FPAY_W-1:0]   removed_payload;
    logic [SEX_W-1:0]    removed_sex;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, removed_payload, removed_sex, entry_count,
                    input ready);
    modport sink   (input valid, status, removed_payload, removed_sex, entry_count,
                    output ready);
endinterface

// ----- rtl/core/psql_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module psql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en) r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/core/psql_ctrl.sv -----
// Sequencer: decodes a command and walks the entry RAM to shift, insert or remove.
`timescale 1ns / 1ps
module psql_ctrl import psql_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cmd_valid,
    output logic     o_cmd_ready,
    input  t_cmd     i_cmd,
    input  logic     i_out_free,
    output logic     o_done,
    output t_result  o_result,
    output t_mem_req o_mem,
    input  t_entry   i_rd_data
);
    t_state  r_state, n_state;
    t_fill   r_fill;
    t_status r_status;
    t_addr   r_at;
    t_addr   r_rd;
    t_addr   r_last;
    logic    r_moves;
    t_entry  r_new;
    t_entry  r_rem;
    logic    r_pend;
    t_addr   r_wr_addr;
    logic    r_cap;
    t_plan   w_plan;
    logic    w_accept;

    assign w_plan   = plan_step(i_cmd.command, i_cmd.position, i_cmd.sex, r_fill);
    assign w_accept = (r_state == S_IDLE) && i_cmd_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (w_plan.op)
                        OP_INSERT: n_state = w_plan.moves ? S_INS_MV : S_PUT;
                        OP_REMOVE: n_state = S_TAKE;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_INS_MV: if (r_rd == r_last) n_state = S_PUT;
            S_PUT:    if (!r_pend) n_state = S_DONE;
            S_TAKE:   n_state = r_moves ? S_REM_MV : S_DRAIN;
            S_REM_MV: if (r_rd == r_last) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_DONE;
            S_DONE:   if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs and RAM port
    always_comb begin
        o_cmd_ready   = (r_state == S_IDLE);
        o_done        = (r_state == S_DONE) && i_out_free;
        o_mem.wr_en   = r_pend;
        o_mem.wr_addr = r_wr_addr;
        o_mem.wr_data = i_rd_data;
        o_mem.rd_en   = 1'b0;
        o_mem.rd_addr = r_rd;
        unique case (r_state)
            S_INS_MV, S_REM_MV: o_mem.rd_en = 1'b1;
            S_TAKE: begin
                o_mem.rd_en   = 1'b1;
                o_mem.rd_addr = r_at;
            end
            S_PUT: begin
                if (!r_pend) begin
                    o_mem.wr_en   = 1'b1;
                    o_mem.wr_addr = r_at;
                    o_mem.wr_data = r_new;
                end
            end
            default: ;
        endcase
    end

    assign o_result.status  = r_status;
    assign o_result.payload = unfit_pay(r_rem.payload);
    assign o_result.sex     = r_rem.sex;
    assign o_result.count   = count_out(r_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_cap   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == S_INS_MV) || (r_state == S_REM_MV);
            r_cap   <= (r_state == S_TAKE);
            if (w_accept) r_fill <= w_plan.fill_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= (r_state == S_INS_MV) ? r_rd + t_addr'(1) : r_rd - t_addr'(1);
        if (w_accept) begin
            r_status      <= w_plan.status;
            r_at          <= w_plan.at;
            r_rd          <= w_plan.first;
            r_last        <= w_plan.last;
            r_moves       <= w_plan.moves;
            r_new.sex     <= i_cmd.sex;
            r_new.payload <= fit_pay(i_cmd.payload);
            r_rem         <= '0;
        end else begin
            if (r_cap) r_rem <= i_rd_data;
            if (r_state == S_INS_MV && r_rd != r_last) r_rd <= r_rd - t_addr'(1);
            if (r_state == S_REM_MV && r_rd != r_last) r_rd <= r_rd + t_addr'(1);
        end
    end
endmodule

// ----- rtl/core/positional_stack_queue_list_top.sv -----
// Top level of the positional stack/queue list: sequencer, entry RAM, result register.
`timescale 1ns / 1ps
// A bounded ordered list of up to DEPTH entries (payload word plus a sex code
// of 1 or 2), usable as a stack or a queue, with insert and remove at a chosen
// 1-based position. Every command transaction gives exactly one result
// transaction carrying status, the removed entry (zero when nothing was
// removed) and the entry count afterwards. Entries live in a single RAM with
// one write and one registered read port; shifting the list is done one entry
// per cycle by a read-then-write pipeline, and a command moves at most DEPTH-2
// entries for an insert and DEPTH-1 for a removal. A rejected or spare
// command goes straight to its result, an append writes its entry first, and
// a removal at the end reads the entry and then drains. The sequencer returns
// to idle before it accepts the next command. One command is worked on at a
// time; the result sits in an output register so the next command is accepted
// while the previous result still waits to be taken. No clearing pass is
// needed after reset: only entries below the fill count are ever read.
module positional_stack_queue_list_top import psql_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    psql_cmd_if.sink      i_cmd,
    psql_res_if.source    o_res
);
    t_cmd     w_cmd;
    t_result  w_result;
    t_mem_req w_mem;
    t_entry   w_rd_data;
    logic     w_done;
    logic     w_out_free;
    logic     w_cmd_ready;

    logic     r_out_valid;
    t_result  r_out;

    // command fields into one bundle for the sequencer
    assign w_cmd.command  = i_cmd.command;
    assign w_cmd.position = i_cmd.position;
    assign w_cmd.payload  = i_cmd.entry_payload;
    assign w_cmd.sex      = i_cmd.entry_sex;
    assign i_cmd.ready    = w_cmd_ready;

    // result register frees up in the same cycle its transaction completes
    assign w_out_free = !r_out_valid || o_res.ready;

    psql_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_out_free  (w_out_free),
        .o_done      (w_done),
        .o_result    (w_result),
        .o_mem       (w_mem),
        .i_rd_data   (w_rd_data)
    );

    psql_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem.wr_en),
        .i_wr_addr (w_mem.wr_addr),
        .i_wr_data (w_mem.wr_data),
        .i_rd_en   (w_mem.rd_en),
        .i_rd_addr (w_mem.rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) r_out <= w_result;
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.status          = r_out.status;
    assign o_res.removed_payload = r_out.payload;
    assign o_res.removed_sex     = r_out.sex;
    assign o_res.entry_count     = r_out.count;

    // sequencer leaves idle on every accepted command
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command accepted twice in a row");

    // failed commands never report a removed entry
    a_fail_no_removal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && w_result.status != ST_OK) |->
            (w_result.payload == '0 && w_result.sex == '0))
        else $error("removed entry reported on failed command");

    // a removed entry always carries a legal sex code
    a_removed_sex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (w_result.sex == '0 || w_result.sex == SEX_A ||
                    w_result.sex == SEX_B))
        else $error("illegal sex code read from entry RAM");

    // result is only loaded when the output register can take it
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (!r_out_valid || o_res.ready))
        else $error("pending result overwritten");
endmodule
